// ===== design/range_sweep_object_segmenter_assert.svh =====
// Assertion macros used by the segmenter top-level design file.
`ifndef RANGE_SWEEP_OBJECT_SEGMENTER_ASSERT_SVH
`define RANGE_SWEEP_OBJECT_SEGMENTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RSOS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("segmenter check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define RSOS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("segmenter check failed: next-cycle implication");

`endif

// ===== design/rsos_pkg.sv =====
// Package with the constants, codes, control structs and width table of the segmenter.
package rsos_pkg;

	localparam int MaxObj      = 16;
	localparam int SweepLimit  = 180;
	localparam int ObjAw       = $clog2(MaxObj);
	localparam int CntW        = $clog2(MaxObj + 1);
	localparam int AngW        = 8;
	localparam int WTabW       = 18;
	localparam int WTabDepth   = 256;
	localparam int DivTenRecip = 6554;
	localparam int DivTenShift = 16;

	localparam logic [7:0] ThrReset  = 8'd60;
	localparam logic [6:0] StepReset = 7'd2;
	localparam logic [4:0] MaxReset  = 5'd16;

	typedef enum logic [1:0] {
		CmdStart  = 2'd0,
		CmdSample = 2'd1,
		CmdSize   = 2'd2,
		CmdBad    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		EvNone   = 2'd0,
		EvClose  = 2'd1,
		EvSize   = 2'd2,
		EvReject = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		RegThreshold = 2'd0,
		RegStep      = 2'd1,
		RegMaxObj    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic cap;
		logic exec;
		logic mul;
	} dp_ctl_t;

	typedef struct packed {
		logic size_ok;
	} dp_sts_t;

	typedef logic [WTabW-1:0] wtab_t [WTabDepth];

	// Multiplies a Q30 series term by the square of x.
	function automatic logic [63:0] series_pow(logic [63:0] term, logic [63:0] x);
		return (((term * x) >> 30) * x) >> 30;
	endfunction

	// Q2.16 chord factor 2*sin(11*d/1260), built by a Q30 Taylor series at elaboration.
	// Each term is divided by (2k)(2k+1) for k from 1 to 15, with alternating signs.
	function automatic wtab_t build_wtab();
		wtab_t              t;
		logic [63:0]        x;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] sum;
		for (int d = 0; d < WTabDepth; d++) begin
			x    = (64'(d) * 64'd11 * (64'd1 << 30)) / 64'd1260;
			term = x;
			sum  = signed'(x);
			term = series_pow(term, x) / 64'd6;   sum = sum - signed'(term);
			term = series_pow(term, x) / 64'd20;  sum = sum + signed'(term);
			term = series_pow(term, x) / 64'd42;  sum = sum - signed'(term);
			term = series_pow(term, x) / 64'd72;  sum = sum + signed'(term);
			term = series_pow(term, x) / 64'd110; sum = sum - signed'(term);
			term = series_pow(term, x) / 64'd156; sum = sum + signed'(term);
			term = series_pow(term, x) / 64'd210; sum = sum - signed'(term);
			term = series_pow(term, x) / 64'd272; sum = sum + signed'(term);
			term = series_pow(term, x) / 64'd342; sum = sum - signed'(term);
			term = series_pow(term, x) / 64'd420; sum = sum + signed'(term);
			term = series_pow(term, x) / 64'd506; sum = sum - signed'(term);
			term = series_pow(term, x) / 64'd600; sum = sum + signed'(term);
			term = series_pow(term, x) / 64'd702; sum = sum - signed'(term);
			term = series_pow(term, x) / 64'd812; sum = sum + signed'(term);
			term = series_pow(term, x) / 64'd930; sum = sum - signed'(term);
			if (sum < 0) begin
				sum = 64'sd0;
			end
			v    = ((64'(sum) * 64'd2) + 64'd8192) >> 14;
			t[d] = v[WTabW-1:0];
		end
		return t;
	endfunction

	localparam wtab_t WidthTab = build_wtab();

endpackage

// ===== design/range_sweep_object_segmenter.sv =====
// A start, sample or rejected request strobes done after the execute state loads the
// result registers; a valid size query registers the divide and the table read in the
// execute state and the width in the multiply state. No new request is taken while busy;
// busy is set by the controller from capture until the result registers are loaded.
// The receiver cannot stall: each result is strobed by done, high for exactly one cycle.
// Reset clears the sweep state and loads threshold 60, step 2 and object limit 16.
module range_sweep_object_segmenter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [7:0]  wr_data,
	input  logic [1:0]  cmd,
	input  logic [7:0]  ir_cm,
	input  logic [3:0]  object_index,
	input  logic [11:0] ping_mm,
	output logic [1:0]  event_res,
	output logic [3:0]  obj_number,
	output logic [7:0]  first_angle,
	output logic [7:0]  last_angle,
	output logic [7:0]  centre_angle,
	output logic [8:0]  distance_cm,
	output logic [9:0]  width_cm,
	output logic [4:0]  count_found,
	output logic        sweep_done
);
	import rsos_pkg::*;

	`include "range_sweep_object_segmenter_assert.svh"

	dp_ctl_t ctl;
	dp_sts_t sts;

	rsos_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	rsos_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.cmd          (cmd),
		.ir_cm        (ir_cm),
		.object_index (object_index),
		.ping_mm      (ping_mm),
		.event_res    (event_res),
		.obj_number   (obj_number),
		.first_angle  (first_angle),
		.last_angle   (last_angle),
		.centre_angle (centre_angle),
		.distance_cm  (distance_cm),
		.width_cm     (width_cm),
		.count_found  (count_found),
		.sweep_done   (sweep_done)
	);

	// A request must occupy the block for the next cycle.
	`RSOS_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	// Results are only strobed once the controller has returned to idle.
	`RSOS_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	// Only a size result carries a distance or a width.
	`RSOS_ASSERT_IMP(a_size_only, clk, arst_n, done && (event_res != EvSize),
		(distance_cm == '0) && (width_cm == '0))
	// The object count never exceeds the store depth.
	`RSOS_ASSERT_IMP(a_count_range, clk, arst_n, done, count_found <= 5'(MaxObj))

endmodule

// ===== design/rsos_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rsos_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/rsos_ctrl.sv =====
// Controller state machine sequencing capture, execute and the width multiply.
module rsos_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  rsos_pkg::dp_sts_t sts,
	output rsos_pkg::dp_ctl_t ctl,
	output logic             busy,
	output logic             done
);
	import rsos_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_MUL  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   strobe_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				state_n = sts.size_ok ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			strobe_q <= ((state_q == S_EXEC) && !sts.size_ok) || (state_q == S_MUL);
		end
	end

	assign ctl.cap  = (state_q == S_IDLE) && start;
	assign ctl.exec = (state_q == S_EXEC);
	assign ctl.mul  = (state_q == S_MUL);
	assign busy     = (state_q != S_IDLE);
	assign done     = strobe_q;

endmodule

// ===== design/rsos_dp.sv =====
// Datapath: configuration, sweep state, angle stores, divider and width multiply.
module rsos_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rsos_pkg::dp_ctl_t ctl,
	output rsos_pkg::dp_sts_t sts,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [7:0]        wr_data,
	input  logic [1:0]        cmd,
	input  logic [7:0]        ir_cm,
	input  logic [3:0]        object_index,
	input  logic [11:0]       ping_mm,
	output logic [1:0]        event_res,
	output logic [3:0]        obj_number,
	output logic [7:0]        first_angle,
	output logic [7:0]        last_angle,
	output logic [7:0]        centre_angle,
	output logic [8:0]        distance_cm,
	output logic [9:0]        width_cm,
	output logic [4:0]        count_found,
	output logic              sweep_done
);
	import rsos_pkg::*;

	// Configuration registers.
	logic [7:0] thr_q;
	logic [6:0] step_q;
	logic [4:0] maxobj_q;

	// Captured request.
	logic [1:0]  cmd_q;
	logic [7:0]  ir_q;
	logic [3:0]  idx_q;
	logic [11:0] ping_q;

	// Sweep state.
	logic [AngW-1:0] angle_q;
	logic            inside_q;
	logic [CntW-1:0] found_q;

	// Next state and derived values.
	logic [AngW-1:0] angle_n;
	logic            inside_n;
	logic [CntW-1:0] found_n;
	logic [CntW-1:0] limit;
	logic            done_cur;
	logic            done_nxt;
	logic            opening;
	logic            closing;
	logic [AngW:0]   angle_sum;
	logic [ObjAw-1:0] raddr;
	logic [AngW-1:0] start_rd;
	logic [AngW-1:0] end_rd;
	logic [AngW-1:0] diff;
	logic [AngW:0]   pair_sum;
	logic [AngW:0]   close_sum;
	logic [24:0]     div_prod;
	logic [26:0]     wid_prod;
	logic [WTabW-1:0] w_s1;

	// Result registers.
	logic [1:0]  ev_q;
	logic [3:0]  num_q;
	logic [7:0]  fa_q;
	logic [7:0]  la_q;
	logic [7:0]  ca_q;
	logic [8:0]  dist_q;
	logic [9:0]  wid_q;
	logic [4:0]  cnt_q;
	logic        sdone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= ThrReset;
			step_q   <= StepReset;
			maxobj_q <= MaxReset;
		end else if (wr_en) begin
			case (wr_index)
				RegThreshold: thr_q    <= wr_data;
				RegStep:      step_q   <= wr_data[6:0];
				RegMaxObj:    maxobj_q <= wr_data[4:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q  <= cmd;
			ir_q   <= ir_cm;
			idx_q  <= object_index;
			ping_q <= ping_mm;
		end
	end

	// The store read is issued at capture so that its data is ready in the execute cycle.
	assign raddr = (cmd == CmdSize) ? object_index : found_q[ObjAw-1:0];

	rsos_ram #(.Width(AngW), .Depth(MaxObj)) u_start_ram (
		.clk   (clk),
		.we    (ctl.exec && opening),
		.waddr (found_q[ObjAw-1:0]),
		.wdata (angle_q),
		.raddr (raddr),
		.rdata (start_rd)
	);

	rsos_ram #(.Width(AngW), .Depth(MaxObj)) u_end_ram (
		.clk   (clk),
		.we    (ctl.exec && closing),
		.waddr (found_q[ObjAw-1:0]),
		.wdata (angle_q),
		.raddr (raddr),
		.rdata (end_rd)
	);

	assign limit    = (maxobj_q < CntW'(MaxObj)) ? maxobj_q : CntW'(MaxObj);
	assign done_cur = (angle_q >= AngW'(SweepLimit)) || (found_q >= limit);

	assign opening = (cmd_q == CmdSample) && !done_cur && (ir_q < thr_q) && !inside_q;
	assign closing = (cmd_q == CmdSample) && !done_cur && (ir_q > thr_q) && inside_q;

	assign angle_sum = {1'b0, angle_q} + {2'b00, step_q};
	assign sts.size_ok = (cmd_q == CmdSize) && ({1'b0, idx_q} < found_q);

	always_comb begin
		angle_n  = angle_q;
		inside_n = inside_q;
		found_n  = found_q;
		case (cmd_q)
			CmdStart: begin
				angle_n  = '0;
				inside_n = 1'b0;
				found_n  = '0;
			end
			CmdSample: begin
				if (!done_cur) begin
					if (opening) begin
						inside_n = 1'b1;
					end else if (closing) begin
						inside_n = 1'b0;
						found_n  = found_q + CntW'(1);
					end
					if (angle_sum > (AngW+1)'(SweepLimit)) begin
						angle_n = AngW'(SweepLimit);
					end else begin
						angle_n = angle_sum[AngW-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign done_nxt = (angle_n >= AngW'(SweepLimit)) || (found_n >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= '0;
			inside_q <= 1'b0;
			found_q  <= '0;
		end else if (ctl.exec) begin
			angle_q  <= angle_n;
			inside_q <= inside_n;
			found_q  <= found_n;
		end
	end

	// Divide by ten through a reciprocal multiply; exact over the twelve-bit range.
	assign div_prod  = {1'b0, ping_q} * 13'(DivTenRecip);
	assign diff      = end_rd - start_rd;
	assign pair_sum  = {1'b0, start_rd} + {1'b0, end_rd};
	assign close_sum = {1'b0, start_rd} + {1'b0, angle_q};
	assign wid_prod  = dist_q * w_s1;

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			ev_q    <= EvNone;
			num_q   <= '0;
			fa_q    <= '0;
			la_q    <= '0;
			ca_q    <= '0;
			dist_q  <= '0;
			wid_q   <= '0;
			cnt_q   <= found_n;
			sdone_q <= done_nxt;
			w_s1    <= WidthTab[diff];
			case (cmd_q)
				CmdSample: begin
					if (done_cur) begin
						ev_q <= EvReject;
					end else if (closing) begin
						ev_q  <= EvClose;
						num_q <= found_q[3:0];
						fa_q  <= start_rd;
						la_q  <= angle_q;
						ca_q  <= close_sum[AngW:1];
					end
				end
				CmdSize: begin
					if (sts.size_ok) begin
						ev_q   <= EvSize;
						num_q  <= idx_q;
						fa_q   <= start_rd;
						la_q   <= end_rd;
						ca_q   <= pair_sum[AngW:1];
						dist_q <= div_prod[DivTenShift+8:DivTenShift];
					end else begin
						ev_q <= EvReject;
					end
				end
				CmdBad: begin
					ev_q <= EvReject;
				end
				default: ;
			endcase
		end else if (ctl.mul) begin
			wid_q <= wid_prod[25:16];
		end
	end

	assign event_res    = ev_q;
	assign obj_number   = num_q;
	assign first_angle  = fa_q;
	assign last_angle   = la_q;
	assign centre_angle = ca_q;
	assign distance_cm  = dist_q;
	assign width_cm     = wid_q;
	assign count_found  = cnt_q;
	assign sweep_done   = sdone_q;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the range sweep object segmenter: a directed script, then random requests.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rsos_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int ChunkCount = 8;
	localparam int ChunkLength = 197;
	localparam int ShownFaults = 40;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  ir;
		logic [3:0]  idx;
		logic [11:0] ping;
	} sweep_req_t;

	typedef struct packed {
		event_t      ev;
		logic [3:0]  num;
		logic [7:0]  fa;
		logic [7:0]  la;
		logic [7:0]  ca;
		logic [8:0]  dist_cm;
		logic [9:0]  wid;
		logic [4:0]  count;
		logic        fin;
	} sweep_evt_t;

	typedef struct {
		bit         is_write;
		reg_idx_t   wreg;
		logic [7:0] wval;
		sweep_req_t req;
		bit         typed;
		sweep_evt_t want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        done;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = 2'd0;
	logic [7:0]  wr_data = 8'd0;
	logic [1:0]  cmd = 2'd0;
	logic [7:0]  ir_cm = 8'd0;
	logic [3:0]  object_index = 4'd0;
	logic [11:0] ping_mm = 12'd0;
	logic [1:0]  event_res;
	logic [3:0]  obj_number;
	logic [7:0]  first_angle;
	logic [7:0]  last_angle;
	logic [7:0]  centre_angle;
	logic [8:0]  distance_cm;
	logic [9:0]  width_cm;
	logic [4:0]  count_found;
	logic        sweep_done;

	range_sweep_object_segmenter dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: sweep position, open object, recorded angles and register copies.
	int          sw_angle;
	bit          sw_open;
	int          sw_found;
	int          sw_first [MaxObj];
	int          sw_last [MaxObj];
	int          cfg_thr = 60;
	int          cfg_step = 2;
	int          cfg_max = 16;
	int unsigned chord_tab [256];

	sweep_evt_t  sweep_events_due [$];
	script_row_t script [$];
	int          idle_pct;
	int          fault_count;
	int          cycle_count;
	sweep_evt_t  oldest;

	// Q2.16 chord factor 2*sin(11*d/1260), summed as a Q30 series.
	function automatic int unsigned chord_q16(int unsigned d);
		longint unsigned x;
		longint unsigned term;
		longint          acc;
		x = ((64'(d) * 64'd11) << 30) / 64'd1260;
		term = x;
		acc = longint'(x);
		for (int n = 1; n <= 15; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		return 32'(($unsigned(acc) * 64'd2 + 64'd8192) >> 14);
	endfunction

	function automatic bit sweep_over();
		int limit;
		limit = (cfg_max < MaxObj) ? cfg_max : MaxObj;
		return (sw_angle >= SweepLimit) || (sw_found >= limit);
	endfunction

	task automatic apply_to_sweep(input sweep_req_t r, output sweep_evt_t e);
		int slot;
		int dist_v;
		int diff;
		e = '0;
		case (r.cmd)
			CmdStart: begin
				sw_angle = 0;
				sw_open = 1'b0;
				sw_found = 0;
			end
			CmdSample: begin
				if (sweep_over()) begin
					e.ev = EvReject;
				end else begin
					slot = sw_found;
					if (r.ir < cfg_thr && !sw_open) begin
						sw_open = 1'b1;
						sw_first[slot] = sw_angle;
					end else if (r.ir > cfg_thr && sw_open) begin
						sw_open = 1'b0;
						sw_last[slot] = sw_angle;
						sw_found = slot + 1;
						e.ev = EvClose;
						e.num = slot[3:0];
						e.fa = sw_first[slot][7:0];
						e.la = sw_angle[7:0];
						e.ca = 8'((sw_first[slot] + sw_angle) >> 1);
					end
					sw_angle = sw_angle + cfg_step;
					if (sw_angle > SweepLimit) begin
						sw_angle = SweepLimit;
					end
				end
			end
			CmdSize: begin
				if (r.idx >= sw_found) begin
					e.ev = EvReject;
				end else begin
					e.ev = EvSize;
					e.num = r.idx;
					e.fa = sw_first[r.idx][7:0];
					e.la = sw_last[r.idx][7:0];
					e.ca = 8'((sw_first[r.idx] + sw_last[r.idx]) >> 1);
					dist_v = r.ping / 10;
					diff = (sw_last[r.idx] - sw_first[r.idx]) & 8'hFF;
					e.dist_cm = dist_v[8:0];
					e.wid = 10'((longint'(dist_v) * chord_tab[diff]) >> 16);
				end
			end
			default: begin
				e.ev = EvReject;
			end
		endcase
		e.count = sw_found[4:0];
		e.fin = sweep_over();
	endtask

	function automatic void add_row(cmd_t c, int ir, int idx, int ping, bit typed,
			event_t ev, int cnt, bit fin);
		script_row_t row;
		row.is_write = 1'b0;
		row.wreg = RegThreshold;
		row.wval = 8'd0;
		row.req.cmd = c;
		row.req.ir = ir[7:0];
		row.req.idx = idx[3:0];
		row.req.ping = ping[11:0];
		row.typed = typed;
		row.want = '0;
		row.want.ev = ev;
		row.want.count = cnt[4:0];
		row.want.fin = fin;
		script.push_back(row);
	endfunction

	function automatic void add_write(reg_idx_t r, int v);
		script_row_t row;
		row.is_write = 1'b1;
		row.wreg = r;
		row.wval = v[7:0];
		row.req = '0;
		row.typed = 1'b0;
		row.want = '0;
		script.push_back(row);
	endfunction

	// Lowers wr_en and lets a clock edge pass before returning, so back-to-back writes never
	// place two assignments on it in one step.
	task automatic write_reg(input reg_idx_t r, input logic [7:0] v);
		wr_en <= 1'b1;
		wr_index <= r;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		case (r)
			RegThreshold: cfg_thr = v;
			RegStep:      cfg_step = v[6:0];
			default:      cfg_max = v[4:0];
		endcase
		@(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sweep_events_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	// Offers one request and returns at the edge that accepts it.
	task automatic send_request(input sweep_req_t r, input bit typed, input sweep_evt_t want,
			output sweep_evt_t pred);
		int gap;
		gap = 0;
		while ($urandom_range(99, 0) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= r.cmd;
		ir_cm <= r.ir;
		object_index <= r.idx;
		ping_mm <= r.ping;
		do @(posedge clk); while (busy);
		apply_to_sweep(r, pred);
		sweep_events_due.push_back(typed ? want : pred);
	endtask

	// Mostly well-formed sweeps: samples that tend to cross the threshold, and
	// size queries aimed at recorded objects, with some noise mixed in.
	function automatic sweep_req_t next_request();
		sweep_req_t r;
		int         roll;
		int         pick;
		bit         high;
		bit         over;
		r.cmd = CmdSample;
		r.ir = 8'($urandom_range(255, 0));
		r.idx = 4'($urandom_range(15, 0));
		r.ping = 12'($urandom_range(4095, 0));
		over = sweep_over();
		roll = $urandom_range(99, 0);
		if (roll < 2) begin
			r.cmd = CmdBad;
		end else if (roll < 5 || (over && roll < 45)) begin
			r.cmd = CmdStart;
		end else if (roll < 30 || (over && roll < 70)) begin
			r.cmd = CmdSize;
			if (sw_found > 0 && $urandom_range(99, 0) < 80) begin
				r.idx = 4'($urandom_range(sw_found - 1, 0));
			end
			pick = $urandom_range(9, 0);
			if (pick == 0) begin
				r.ping = 12'd0;
			end else if (pick == 1) begin
				r.ping = 12'hFFF;
			end
		end else begin
			pick = $urandom_range(99, 0);
			if (pick < 8) begin
				r.ir = cfg_thr[7:0];
			end else if (pick >= 20) begin
				high = (sw_open != (pick < 60));
				if (high && cfg_thr < 255) begin
					r.ir = 8'($urandom_range(255, cfg_thr + 1));
				end else if (!high && cfg_thr > 0) begin
					r.ir = 8'($urandom_range(cfg_thr - 1, 0));
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fault_count++;
			if (fault_count <= ShownFaults) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sweep_events_due.size() == 0) begin
				fault_count++;
				if (fault_count <= ShownFaults) begin
					$display("%0t: result expected none actual event %0d", $time, event_res);
				end
			end else begin
				oldest = sweep_events_due.pop_front();
				check_field("event_res", oldest.ev, event_res);
				check_field("obj_number", oldest.num, obj_number);
				check_field("first_angle", oldest.fa, first_angle);
				check_field("last_angle", oldest.la, last_angle);
				check_field("centre_angle", oldest.ca, centre_angle);
				check_field("distance_cm", oldest.dist_cm, distance_cm);
				check_field("width_cm", oldest.wid, width_cm);
				check_field("count_found", oldest.count, count_found);
				check_field("sweep_done", oldest.fin, sweep_done);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int         idle_tab [4];
		int         sent;
		int         pick;
		logic [7:0] thr_v;
		logic [7:0] step_v;
		logic [7:0] max_v;
		sweep_req_t r;
		sweep_evt_t pred;
		idle_tab = '{0, 73, 0, 26};
		for (int d = 0; d < 256; d++) begin
			chord_tab[d] = chord_q16(d);
		end

		// Straight out of reset: nothing recorded, so queries are refused.
		add_row(CmdSize,   0,   0,  4095, 1'b1, EvReject, 0, 1'b0);
		add_row(CmdBad,    255, 15, 4095, 1'b1, EvReject, 0, 1'b0);
		add_row(CmdStart,  0,   0,  0,    1'b1, EvNone,   0, 1'b0);
		add_row(CmdSample, 60,  0,  0,    1'b1, EvNone,   0, 1'b0);
		add_row(CmdSample, 0,   0,  0,    1'b1, EvNone,   0, 1'b0);
		add_row(CmdSample, 255, 0,  0,    1'b0, EvNone,   0, 1'b0);
		add_row(CmdSize,   0,   0,  4095, 1'b0, EvNone,   0, 1'b0);
		add_row(CmdSize,   0,   1,  4095, 1'b1, EvReject, 1, 1'b0);
		// Left open here; the next start must drop it.
		add_row(CmdSample, 0,   0,  0,    1'b1, EvNone,   1, 1'b0);
		add_write(RegStep, 90);
		add_row(CmdStart,  0,   0,  0,    1'b1, EvNone,   0, 1'b0);
		add_row(CmdSample, 0,   0,  0,    1'b0, EvNone,   0, 1'b0);
		add_row(CmdSample, 255, 0,  0,    1'b0, EvNone,   0, 1'b0);
		add_row(CmdSample, 0,   0,  0,    1'b1, EvReject, 1, 1'b1);
		add_row(CmdSize,   0,   0,  4095, 1'b0, EvNone,   0, 1'b0);
		// A zero step keeps the angle still, giving a zero-width object.
		add_write(RegStep, 0);
		add_row(CmdStart,  0,   0,  0,    1'b1, EvNone,   0, 1'b0);
		add_row(CmdSample, 0,   0,  0,    1'b0, EvNone,   0, 1'b0);
		add_row(CmdSample, 255, 0,  0,    1'b0, EvNone,   0, 1'b0);
		add_row(CmdSize,   0,   0,  4095, 1'b0, EvNone,   0, 1'b0);
		// With no objects allowed the sweep is over as soon as it starts.
		add_write(RegMaxObj, 0);
		add_row(CmdStart,  0,   0,  0,    1'b1, EvNone,   0, 1'b1);
		add_row(CmdSample, 0,   0,  0,    1'b1, EvReject, 0, 1'b1);
		// A large step runs the angle past the end of the sweep, where it is clamped.
		add_write(RegStep, 127);
		add_write(RegMaxObj, 1);
		add_write(RegThreshold, 255);
		add_row(CmdStart,  0,   0,  0,    1'b1, EvNone,   0, 1'b0);
		add_row(CmdSample, 0,   0,  0,    1'b0, EvNone,   0, 1'b0);
		add_row(CmdSample, 255, 0,  0,    1'b0, EvNone,   0, 1'b0);
		add_row(CmdSample, 255, 0,  0,    1'b1, EvReject, 0, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 26;
		foreach (script[i]) begin
			if (script[i].is_write) begin
				settle();
				write_reg(script[i].wreg, script[i].wval);
			end else begin
				send_request(script[i].req, script[i].typed, script[i].want, pred);
			end
		end

		for (int chunk = 0; chunk < ChunkCount; chunk++) begin
			idle_pct = idle_tab[chunk % 4];
			if (chunk == 0) begin
				thr_v = 8'd60;
				step_v = 8'd2;
				max_v = 8'd31;
			end else begin
				pick = $urandom_range(9, 0);
				thr_v = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
					8'($urandom_range(230, 20));
				pick = $urandom_range(9, 0);
				step_v = (pick == 0) ? 8'd1 : (pick == 1) ? 8'd90 :
					8'($urandom_range(12, 1));
				pick = $urandom_range(9, 0);
				max_v = (pick == 0) ? 8'd1 : (pick == 1) ? 8'd16 :
					8'($urandom_range(16, 1));
			end
			settle();
			write_reg(RegThreshold, thr_v);
			write_reg(RegStep, step_v);
			write_reg(RegMaxObj, max_v);
			sent = 0;
			while (sent < ChunkLength) begin
				r = next_request();
				send_request(r, 1'b0, '0, pred);
				sent++;
			end
		end

		settle();
		if (fault_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
